// ===== hw/rtl/sha256_stream_hasher_unit_assert.svh =====
// Assertion macros used by the SHA-256 sequencer (sha256_ctrl).
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA_ASSERT_IMP(label, ante, cons, msg)
`define SHA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sha256_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 hasher.
// Depends on nothing. Imported by sha256_round, sha256_ctrl and sha256_stream_hasher_unit.
package sha256_pkg;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] PAD_LIMIT = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // What the block being compressed is: a full data block, the first of two
  // padding blocks, or the block that carries the length.
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic        byte_we;
    logic [5:0]  byte_pos;
    logic [7:0]  byte_val;
    logic        len_we;
    logic [63:0] len_bits;
    logic        load_vars;
    logic        round_en;
    logic [5:0]  round_idx;
    logic        add_chain;
    logic        clear_block;
    logic        reset_chain;
    logic [2:0]  rd_idx;
  } ctl_t;

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== hw/rtl/sha256_stream_if.sv =====
// Handshake channels of the SHA-256 hasher: message bytes in, digest words out.
// Depends on nothing.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output has_byte, output is_last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input is_last,
                output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== hw/rtl/sha256_round.sv =====
// SHA-256 datapath: block buffer with rolling schedule, working variables,
// chaining value and the one-round-per-cycle compression unit. Uses sha256_pkg.
module sha256_round
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output logic [31:0] digest_word
);

  logic [31:0] chain [8];
  logic [31:0] words [16];
  logic [31:0] vars [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] w_new;
  logic [4:0]  lane_base;

  assign digest_word = chain[ctl.rd_idx];

  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1  = vars[7] + big_s1(vars[4]) + ch + ROUND_K[ctl.round_idx] + words[0];
  assign t2  = big_s0(vars[0]) + maj;

  // The window always holds W[t..t+15]; the word entering at the top is
  // W[t+16], which is harmless to compute during the first 16 rounds too.
  assign w_new = small_s1(words[14]) + words[9] + small_s0(words[1]) + words[0];

  // Bytes are packed big-endian, so byte 0 of a word sits in bits 31:24.
  assign lane_base = {~ctl.byte_pos[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) chain[k] <= INIT_HASH[k];
    end else if (ctl.reset_chain) begin
      for (int k = 0; k < 8; k++) chain[k] <= INIT_HASH[k];
    end else if (ctl.add_chain) begin
      for (int k = 0; k < 8; k++) chain[k] <= chain[k] + vars[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_block) begin
      for (int k = 0; k < 16; k++) words[k] <= 32'd0;
    end else begin
      if (ctl.round_en) begin
        for (int k = 0; k < 15; k++) words[k] <= words[k + 1];
        words[15] <= w_new;
      end
      if (ctl.byte_we) begin
        words[ctl.byte_pos[5:2]][lane_base +: 8] <= ctl.byte_val;
      end
      if (ctl.len_we) begin
        words[14] <= ctl.len_bits[63:32];
        words[15] <= ctl.len_bits[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_vars) begin
      for (int k = 0; k < 8; k++) vars[k] <= chain[k];
    end else if (ctl.round_en) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
// SHA-256 sequencer: byte position and message length, padding steps, round
// counter and digest readout. Uses sha256_pkg and the assertion macro header.
`include "sha256_stream_hasher_unit_assert.svh"
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       is_last,
  input  logic       out_free,
  output logic       in_ready,
  output logic       emit_load,
  output ctl_t       ctl
);

  state_t      state;
  state_t      state_next;
  phase_t      phase;
  logic        last_pend;
  logic [5:0]  rnd;
  logic [60:0] count;
  logic [2:0]  emit_idx;
  logic        pos_high;

  assign pos_high = count[5:0] >= PAD_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_DATA;
      last_pend <= 1'b0;
      rnd       <= 6'd0;
      count     <= 61'd0;
      emit_idx  <= 3'd0;
    end else begin
      state <= state_next;
      if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (in_fire) begin
        phase     <= PH_DATA;
        last_pend <= is_last;
        if (has_byte) begin
          count <= count + 61'd1;
        end
      end
      if (state == ST_PAD) begin
        phase <= pos_high ? PH_PAD : PH_FINAL;
      end
      if (state == ST_LEN) begin
        phase <= PH_FINAL;
      end
      if (emit_load) begin
        emit_idx <= emit_idx + 3'd1;
        if (emit_idx == LAST_IDX) begin
          count <= 61'd0;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_byte && count[5:0] == LAST_POS) begin
            state_next = ST_LOAD;
          end else if (is_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD:   state_next = ST_LOAD;
      ST_LEN:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == LAST_RND) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        case (phase)
          PH_DATA:  state_next = last_pend ? ST_PAD : ST_IDLE;
          PH_PAD:   state_next = ST_LEN;
          PH_FINAL: state_next = ST_EMIT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_free && emit_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    emit_load       = 1'b0;
    ctl             = '0;
    ctl.byte_pos    = count[5:0];
    ctl.byte_val    = data_byte;
    ctl.len_bits    = {count, 3'b000};
    ctl.round_idx   = rnd;
    ctl.rd_idx      = emit_idx;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.byte_we = in_fire && has_byte;
      end
      ST_PAD: begin
        // The 0x80 marker always goes in; the length fits only if the
        // marker left at least eight bytes free.
        ctl.byte_we  = 1'b1;
        ctl.byte_val = PAD_BYTE;
        ctl.len_we   = !pos_high;
      end
      ST_LEN:   ctl.len_we = 1'b1;
      ST_LOAD:  ctl.load_vars = 1'b1;
      ST_ROUND: ctl.round_en = 1'b1;
      ST_ADD: begin
        ctl.add_chain   = 1'b1;
        ctl.clear_block = 1'b1;
      end
      ST_EMIT: begin
        emit_load       = out_free;
        ctl.reset_chain = out_free && emit_idx == LAST_IDX;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `SHA_ASSERT_IMP(a_rnd_idle, state != ST_ROUND, rnd == 6'd0, "round counter moved outside compression")
  `SHA_ASSERT_NEXT(a_round_end, state == ST_ROUND && rnd == LAST_RND, state == ST_ADD, "compression did not end after 64 rounds")
  `SHA_ASSERT_NEXT(a_final_emit, state == ST_ADD && phase == PH_FINAL, state == ST_EMIT, "final block not followed by digest readout")
  `SHA_ASSERT_NEXT(a_emit_done, emit_load && emit_idx == LAST_IDX, state == ST_IDLE && count == 61'd0, "message state not cleared after digest")

endmodule

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// SHA-256 stream hasher: takes at most one message byte per item, emits eight digest words.
// A byte item that does not fill a block is only stored; a block-filling byte also starts
// compression (load, the rounds on the single round unit, chain add). A closing item adds a
// padding step and compression, plus a length step and a second compression when a second
// padding block is needed, then the digest words. Items wait while compression or output runs.
// Reset (synchronous, rst high): chaining value to the initial hash, block and length cleared.
module sha256_stream_hasher_unit
  import sha256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sha256_in_if.sink    data_in,
  sha256_out_if.source digest_out
);

  logic        in_ready;
  logic        in_fire;
  logic        out_free;
  logic        emit_load;
  ctl_t        ctl;
  logic [31:0] sel_word;
  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_index;
  logic        out_last;

  assign data_in.ready = in_ready;
  assign in_fire       = data_in.valid && in_ready;
  assign out_free      = !out_valid || digest_out.ready;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_in.data_byte),
    .has_byte  (data_in.has_byte),
    .is_last   (data_in.is_last),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .emit_load (emit_load),
    .ctl       (ctl)
  );

  sha256_round u_round (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .digest_word (sel_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (digest_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_word  <= sel_word;
      out_index <= ctl.rd_idx;
      out_last  <= ctl.rd_idx == LAST_IDX;
    end
  end

  assign digest_out.valid       = out_valid;
  assign digest_out.digest_word = out_word;
  assign digest_out.word_index  = out_index;
  assign digest_out.last_word   = out_last;

endmodule
